// ===== hdl/radar_track_frame_decoder_unit_assert.svh =====
// Assertion macros used by the radar track frame decoder sequencer
`ifndef RADAR_TRACK_FRAME_DECODER_UNIT_ASSERT_SVH
`define RADAR_TRACK_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RTFD_CHK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define RTFD_CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rtfd_pkg.sv =====
// Shared types, constants and the sine table of the radar track frame decoder
package rtfd_pkg;

    localparam int SINE_TABLE_ENTRIES = 513;
    localparam int SIN_N     = SINE_TABLE_ENTRIES - 1;
    localparam int ADDR_W    = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int ROM_DEPTH = 2 ** ADDR_W;
    localparam int SUB_W     = ADDR_W - 8;
    localparam int NSUB      = 2 ** SUB_W;
    localparam int SIN_W     = 15;
    localparam longint SIN_N_L = longint'(SIN_N);

    localparam int NUM_W  = 25;
    localparam int RCP_W  = 21;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam int RECIP  = (2 ** 30) / 900;

    localparam int TDATA_IN_W  = 96;
    localparam int TDATA_OUT_W = 96;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [10:0] ID_SCAN_OPEN = 11'h500;
    localparam logic [10:0] ID_TRK_FIRST = 11'h501;
    localparam logic [10:0] ID_TRK_LAST  = 11'h53F;

    localparam logic [CFG_ADDR_W-1:0] CFG_EGO_EN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRESH    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCAN_LEN = 2'd2;

    localparam logic [15:0] FRESH_RST    = 16'd500;
    localparam logic [6:0]  SCAN_LEN_RST = 7'd32;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_EGO   = 2'd1,
        OP_TICK  = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_EGO_LD,
        CMD_LOAD,
        CMD_NUM,
        CMD_DMUL,
        CMD_DFIX_IDX,
        CMD_RLO,
        CMD_RHI,
        CMD_INTERP,
        CMD_DFIX_Q,
        CMD_SAVE,
        CMD_EGO,
        CMD_RR,
        CMD_PX,
        CMD_PY,
        CMD_VX,
        CMD_VY,
        CMD_FIN,
        CMD_OUT
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd cmd;
        logic    pass;   // 0: cosine, 1: sine
        logic    comp;   // add ego projection
    } t_dp_ctrl;

    typedef logic [SIN_W-1:0] t_sin_rom [ROM_DEPTH];

    // term * x * x in Q30
    function automatic longint q30_sq(longint t, longint x);
        longint p;
        p = t * x / 64'sd1073741824;
        p = p * x / 64'sd1073741824;
        return p;
    endfunction

    // quarter-wave sine in Q0.15 from a Q30 Taylor series; padding reads as zero
    function automatic t_sin_rom build_sin_rom();
        t_sin_rom rom;
        longint x;
        longint term;
        longint sum;
        longint v;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            if (k < SINE_TABLE_ENTRIES) begin
                x    = 64'sd1686629713 * longint'(k) / SIN_N_L;
                term = x;
                sum  = x;
                term = -q30_sq(term, x) / 64'sd6;
                sum  = sum + term;
                term = -q30_sq(term, x) / 64'sd20;
                sum  = sum + term;
                term = -q30_sq(term, x) / 64'sd42;
                sum  = sum + term;
                term = -q30_sq(term, x) / 64'sd72;
                sum  = sum + term;
                term = -q30_sq(term, x) / 64'sd110;
                sum  = sum + term;
                term = -q30_sq(term, x) / 64'sd156;
                sum  = sum + term;
                v = (sum > 0) ? (sum + 64'sd16384) / 64'sd32768 : 64'sd0;
                if (v > 64'sd32767) v = 64'sd32767;
                rom[k] = SIN_W'(v);
            end else begin
                rom[k] = '0;
            end
        end
        return rom;
    endfunction

    localparam t_sin_rom SIN_ROM = build_sin_rom();

endpackage

// ===== hdl/rtfd_ctrl.sv =====
// Sequencer, scan and ego-speed bookkeeping and configuration registers
`include "radar_track_frame_decoder_unit_assert.svh"

module rtfd_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic [1:0]                          i_s_tuser,
    input  logic [10:0]                         i_can_id,
    output logic                                o_s_tready,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_we,
    input  logic [rtfd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rtfd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output rtfd_pkg::t_dp_ctrl                  o_ctrl
);

    typedef enum logic [4:0] {
        S_IDLE, S_NUM, S_DMUL, S_DFIX, S_RLO, S_RHI, S_INTERP, S_DMUL2, S_DFIX2,
        S_SAVE, S_EGO, S_RR, S_PX, S_PY, S_VX, S_VY, S_FIN, S_OUT
    } t_state;

    t_state        r_state;
    logic          r_pass;
    logic          r_comp;
    logic          r_last;
    logic          r_m_valid;
    logic          r_m_last;
    logic          r_scan_open;
    logic [6:0]    r_tracks;
    logic          r_seen;
    logic [15:0]   r_age;
    logic          r_ego_en;
    logic [15:0]   r_fresh;
    logic [6:0]    r_scan_len;

    rtfd_pkg::t_op op;
    logic          acc;
    logic          id_open;
    logic          id_cont;
    logic          take_track;
    logic [6:0]    cnt_next;
    logic          last;
    logic          out_free;

    assign op         = rtfd_pkg::t_op'(i_s_tuser);
    assign acc        = i_s_tvalid && (r_state == S_IDLE);
    assign id_open    = (i_can_id == rtfd_pkg::ID_SCAN_OPEN);
    assign id_cont    = r_scan_open && (i_can_id >= rtfd_pkg::ID_TRK_FIRST)
                        && (i_can_id <= rtfd_pkg::ID_TRK_LAST);
    assign take_track = acc && (op == rtfd_pkg::OP_FRAME) && (id_open || id_cont);
    assign cnt_next   = (id_open ? 7'd0 : r_tracks) + 7'd1;
    assign last       = (cnt_next >= r_scan_len);
    assign out_free   = !r_m_valid || i_m_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tlast  = r_m_last;

    always_comb begin
        o_ctrl.pass = r_pass;
        o_ctrl.comp = r_comp;
        case (r_state)
            S_IDLE: begin
                if (take_track) begin
                    o_ctrl.cmd = rtfd_pkg::CMD_LOAD;
                end else if (acc && op == rtfd_pkg::OP_EGO) begin
                    o_ctrl.cmd = rtfd_pkg::CMD_EGO_LD;
                end else begin
                    o_ctrl.cmd = rtfd_pkg::CMD_NONE;
                end
            end
            S_NUM:    o_ctrl.cmd = rtfd_pkg::CMD_NUM;
            S_DMUL:   o_ctrl.cmd = rtfd_pkg::CMD_DMUL;
            S_DFIX:   o_ctrl.cmd = rtfd_pkg::CMD_DFIX_IDX;
            S_RLO:    o_ctrl.cmd = rtfd_pkg::CMD_RLO;
            S_RHI:    o_ctrl.cmd = rtfd_pkg::CMD_RHI;
            S_INTERP: o_ctrl.cmd = rtfd_pkg::CMD_INTERP;
            S_DMUL2:  o_ctrl.cmd = rtfd_pkg::CMD_DMUL;
            S_DFIX2:  o_ctrl.cmd = rtfd_pkg::CMD_DFIX_Q;
            S_SAVE:   o_ctrl.cmd = rtfd_pkg::CMD_SAVE;
            S_EGO:    o_ctrl.cmd = rtfd_pkg::CMD_EGO;
            S_RR:     o_ctrl.cmd = rtfd_pkg::CMD_RR;
            S_PX:     o_ctrl.cmd = rtfd_pkg::CMD_PX;
            S_PY:     o_ctrl.cmd = rtfd_pkg::CMD_PY;
            S_VX:     o_ctrl.cmd = rtfd_pkg::CMD_VX;
            S_VY:     o_ctrl.cmd = rtfd_pkg::CMD_VY;
            S_FIN:    o_ctrl.cmd = rtfd_pkg::CMD_FIN;
            S_OUT:    o_ctrl.cmd = out_free ? rtfd_pkg::CMD_OUT : rtfd_pkg::CMD_NONE;
            default:  o_ctrl.cmd = rtfd_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= 1'b0;
            r_comp      <= 1'b0;
            r_last      <= 1'b0;
            r_m_valid   <= 1'b0;
            r_m_last    <= 1'b0;
            r_scan_open <= 1'b0;
            r_tracks    <= 7'd0;
            r_seen      <= 1'b0;
            r_age       <= 16'd0;
            r_ego_en    <= 1'b1;
            r_fresh     <= rtfd_pkg::FRESH_RST;
            r_scan_len  <= rtfd_pkg::SCAN_LEN_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rtfd_pkg::CFG_EGO_EN:   r_ego_en   <= i_cfg_wdata[0];
                    rtfd_pkg::CFG_FRESH:    r_fresh    <= i_cfg_wdata;
                    rtfd_pkg::CFG_SCAN_LEN: r_scan_len <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
                r_m_last  <= r_last;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc && op == rtfd_pkg::OP_EGO) begin
                        r_seen <= 1'b1;
                        r_age  <= 16'd0;
                    end
                    if (acc && op == rtfd_pkg::OP_TICK && r_age != 16'hFFFF) begin
                        r_age <= r_age + 16'd1;
                    end
                    if (take_track) begin
                        r_tracks    <= cnt_next;
                        r_scan_open <= !last;
                        r_last      <= last;
                        r_pass      <= 1'b0;
                        r_comp      <= r_ego_en && r_seen && (r_age < r_fresh);
                        r_state     <= S_NUM;
                    end
                end
                S_NUM:    r_state <= S_DMUL;
                S_DMUL:   r_state <= S_DFIX;
                S_DFIX:   r_state <= S_RLO;
                S_RLO:    r_state <= S_RHI;
                S_RHI:    r_state <= S_INTERP;
                S_INTERP: r_state <= S_DMUL2;
                S_DMUL2:  r_state <= S_DFIX2;
                S_DFIX2:  r_state <= S_SAVE;
                S_SAVE: begin
                    if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_state <= S_NUM;
                    end else begin
                        r_state <= S_EGO;
                    end
                end
                S_EGO:    r_state <= S_RR;
                S_RR:     r_state <= S_PX;
                S_PX:     r_state <= S_PY;
                S_PY:     r_state <= S_VX;
                S_VX:     r_state <= S_VY;
                S_VY:     r_state <= S_FIN;
                S_FIN:    r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    `RTFD_CHK_NXT(a_track_busy, take_track, r_state != S_IDLE, "track item did not start work")
    `RTFD_CHK_NXT(a_last_closes, take_track && last, !r_scan_open, "scan open after last track")
    `RTFD_CHK_NXT(a_tick_age, acc && op == rtfd_pkg::OP_TICK && r_age != 16'hFFFF,
                  r_age == $past(r_age) + 16'd1, "tick did not advance age")
    `RTFD_CHK_IMP(a_out_only_when_free, o_ctrl.cmd == rtfd_pkg::CMD_OUT,
                  !r_m_valid || i_m_tready, "result overwrote a waiting item")

endmodule

// ===== hdl/rtfd_datapath.sv =====
// Field unpacking, sine lookup with interpolation and Cartesian conversion
module rtfd_datapath (
    input  logic                                 i_clk,
    input  rtfd_pkg::t_dp_ctrl                   i_ctrl,
    input  logic [rtfd_pkg::TDATA_IN_W-1:0]      i_tdata,
    output logic [rtfd_pkg::TDATA_OUT_W-1:0]     o_tdata
);

    logic [63:0]   pl;
    logic [9:0]    araw;
    logic [13:0]   rrraw;
    logic signed [17:0] rate_ext;

    logic [6:0]    r_id;
    logic [2:0]    r_status;
    logic [17:0]   r_range100;
    logic [9:0]    r_mag;
    logic          r_ang_pos;
    logic signed [17:0] r_rate10;
    logic [3:0]    r_width;
    logic          r_rc;
    logic [16:0]   r_ego;

    logic [rtfd_pkg::NUM_W-1:0]  r_num;
    logic [rtfd_pkg::PROD_W-1:0] r_prod;
    logic [rtfd_pkg::ADDR_W-1:0] r_idx;
    logic [9:0]                  r_rem;
    logic [rtfd_pkg::SIN_W-1:0]  r_sub [rtfd_pkg::NSUB];
    logic [rtfd_pkg::SUB_W-1:0]  r_sel;
    logic [rtfd_pkg::SIN_W-1:0]  r_lo;
    logic [rtfd_pkg::SIN_W-1:0]  r_q;
    logic [rtfd_pkg::SIN_W-1:0]  r_c;
    logic [rtfd_pkg::SIN_W-1:0]  r_s;
    logic                        r_rr_neg;
    logic [17:0]                 r_rr_mag;
    logic [17:0]                 r_px;
    logic [17:0]                 r_py;
    logic [17:0]                 r_vx;
    logic [17:0]                 r_vy;
    logic [rtfd_pkg::TDATA_OUT_W-1:0] r_out;

    logic [rtfd_pkg::NUM_W-1:0]  mul_a;
    logic [rtfd_pkg::RCP_W-1:0]  mul_b;
    logic [rtfd_pkg::PROD_W-1:0] mul_p;
    logic [9:0]                  t_sel;
    logic [rtfd_pkg::SIN_W-1:0]  hi;
    logic [rtfd_pkg::SIN_W-1:0]  diff;
    logic [15:0]                 q0;
    logic [25:0]                 q900;
    logic [25:0]                 rem_full;
    logic [15:0]                 q_fix;
    logic [9:0]                  rem_fix;
    logic [rtfd_pkg::PROD_W-1:0] rnd_sum;
    logic [18:0]                 rnd;
    logic [17:0]                 rnd_sat;
    logic signed [19:0]          rr;
    logic [19:0]                 rr_abs;
    logic [rtfd_pkg::ADDR_W-1:0] rd_addr;
    logic [18:0]                 py_s;
    logic [18:0]                 vx_s;
    logic [18:0]                 vy_s;

    assign pl       = i_tdata[74:11];
    assign araw     = {pl[12:8], pl[23:19]};
    assign rrraw    = {pl[53:48], pl[63:56]};
    assign rate_ext = {{4{rrraw[13]}}, rrraw};

    assign t_sel = i_ctrl.pass ? r_mag : (10'd900 - r_mag);
    assign hi    = r_sub[r_sel];
    // no right neighbour is needed when the position falls on an entry
    assign diff  = (r_rem == 10'd0) ? '0 : (hi - r_lo);

    always_comb begin
        case (i_ctrl.cmd)
            rtfd_pkg::CMD_DMUL: begin
                mul_a = r_num;
                mul_b = rtfd_pkg::RCP_W'(rtfd_pkg::RECIP);
            end
            rtfd_pkg::CMD_INTERP: begin
                mul_a = rtfd_pkg::NUM_W'(diff);
                mul_b = rtfd_pkg::RCP_W'(r_rem);
            end
            rtfd_pkg::CMD_EGO: begin
                mul_a = rtfd_pkg::NUM_W'(r_ego);
                mul_b = rtfd_pkg::RCP_W'(r_c);
            end
            rtfd_pkg::CMD_PX: begin
                mul_a = rtfd_pkg::NUM_W'(r_range100);
                mul_b = rtfd_pkg::RCP_W'(r_c);
            end
            rtfd_pkg::CMD_PY: begin
                mul_a = rtfd_pkg::NUM_W'(r_range100);
                mul_b = rtfd_pkg::RCP_W'(r_s);
            end
            rtfd_pkg::CMD_VX: begin
                mul_a = rtfd_pkg::NUM_W'(r_rr_mag);
                mul_b = rtfd_pkg::RCP_W'(r_c);
            end
            rtfd_pkg::CMD_VY: begin
                mul_a = rtfd_pkg::NUM_W'(r_rr_mag);
                mul_b = rtfd_pkg::RCP_W'(r_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = rtfd_pkg::PROD_W'(mul_a) * rtfd_pkg::PROD_W'(mul_b);

    // divide by 900: reciprocal estimate is low by at most one
    assign q0       = r_prod[rtfd_pkg::PROD_W-1:30];
    assign q900     = 26'(q0) * 26'd900;
    assign rem_full = 26'(r_num) - q900;
    always_comb begin
        if (rem_full >= 26'd900) begin
            q_fix   = q0 + 16'd1;
            rem_fix = 10'(rem_full - 26'd900);
        end else begin
            q_fix   = q0;
            rem_fix = rem_full[9:0];
        end
    end

    // Q15 rounding of a magnitude
    assign rnd_sum = r_prod + rtfd_pkg::PROD_W'(16384);
    assign rnd     = rnd_sum[33:15];
    assign rnd_sat = (rnd > 19'd200000) ? 18'd200000 : rnd[17:0];

    assign rr     = {{2{r_rate10[17]}}, r_rate10} + (i_ctrl.comp ? {1'b0, rnd} : 20'sd0);
    assign rr_abs = rr[19] ? 20'(-rr) : 20'(rr);

    assign rd_addr = (i_ctrl.cmd == rtfd_pkg::CMD_RHI) ? (r_idx + 1'b1) : r_idx;

    assign py_s = r_ang_pos ? 19'(-{1'b0, r_py}) : {1'b0, r_py};
    assign vx_s = r_rr_neg ? 19'(-{1'b0, r_vx}) : {1'b0, r_vx};
    assign vy_s = (r_rr_neg ^ r_ang_pos) ? 19'(-{1'b0, r_vy}) : {1'b0, r_vy};

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            rtfd_pkg::CMD_EGO_LD: r_ego <= i_tdata[91:75];
            rtfd_pkg::CMD_LOAD: begin
                r_id       <= 7'(i_tdata[5:0]) + 7'd1;
                r_status   <= pl[15:13];
                r_range100 <= 18'({pl[18:16], pl[31:24]}) * 18'd100;
                r_mag      <= araw[9] ? 10'(-araw) : araw;
                r_ang_pos  <= !araw[9] && (araw != 10'd0);
                r_rate10   <= (rate_ext <<< 3) + (rate_ext <<< 1);
                r_width    <= pl[37:34];
                r_rc       <= pl[38];
            end
            rtfd_pkg::CMD_NUM:    r_num  <= rtfd_pkg::NUM_W'(t_sel)
                                           * rtfd_pkg::NUM_W'(rtfd_pkg::SIN_N);
            rtfd_pkg::CMD_DMUL:   r_prod <= mul_p;
            rtfd_pkg::CMD_DFIX_IDX: begin
                r_idx <= q_fix[rtfd_pkg::ADDR_W-1:0];
                r_rem <= rem_fix;
            end
            rtfd_pkg::CMD_RLO, rtfd_pkg::CMD_RHI: begin
                for (int j = 0; j < rtfd_pkg::NSUB; j++) begin
                    r_sub[j] <= rtfd_pkg::SIN_ROM[{rtfd_pkg::SUB_W'(j), rd_addr[7:0]}];
                end
                r_sel <= rd_addr[rtfd_pkg::ADDR_W-1:8];
                if (i_ctrl.cmd == rtfd_pkg::CMD_RHI) begin
                    r_lo <= r_sub[r_sel];
                end
            end
            rtfd_pkg::CMD_INTERP: r_num <= rtfd_pkg::NUM_W'(mul_p)
                                           + rtfd_pkg::NUM_W'(450);
            rtfd_pkg::CMD_DFIX_Q: r_q <= q_fix[rtfd_pkg::SIN_W-1:0];
            rtfd_pkg::CMD_SAVE: begin
                if (i_ctrl.pass) begin
                    r_s <= r_lo + r_q;
                end else begin
                    r_c <= r_lo + r_q;
                end
            end
            rtfd_pkg::CMD_EGO:    r_prod <= mul_p;
            rtfd_pkg::CMD_RR: begin
                r_rr_neg <= rr[19];
                r_rr_mag <= rr_abs[17:0];
            end
            rtfd_pkg::CMD_PX:     r_prod <= mul_p;
            rtfd_pkg::CMD_PY: begin
                r_px   <= rnd[17:0];
                r_prod <= mul_p;
            end
            rtfd_pkg::CMD_VX: begin
                r_py   <= rnd[17:0];
                r_prod <= mul_p;
            end
            rtfd_pkg::CMD_VY: begin
                r_vx   <= rnd_sat;
                r_prod <= mul_p;
            end
            rtfd_pkg::CMD_FIN:    r_vy <= rnd_sat;
            rtfd_pkg::CMD_OUT: begin
                r_out <= {5'd0, r_rc, r_width, vy_s, vx_s, py_s,
                          {1'b0, r_px}, r_status, r_id};
            end
            default: ;
        endcase
    end

    assign o_tdata = r_out;

endmodule

// ===== hdl/radar_track_frame_decoder_unit.sv =====
// Radar track frame decoder: top level joining sequencer and datapath
// Input stream: tuser = operation (0 CAN frame, 1 ego speed, 2 ms tick).
//   tdata carries can_id, payload and ego speed. Ticks, ego updates and
//   frames that are not tracks of an open scan give no result.
// A track frame (id 0x500, or 0x501..0x53F with a scan open) gives one
//   result; the block takes no new item until that track has left its
//   final step. The shared multiplier handles two sine lookups (divide by
//   900, table read, interpolation) and five products in turn.
// Output stream: tdata holds the track fields, tlast marks the track that
//   completes the scan. The result sits in an output register; the block
//   takes further items while it waits and holds the next track in its
//   final step until the register frees.
// Configuration: i_cfg_we writes register i_cfg_addr (0 ego compensation
//   enable, 1 freshness limit in ms ticks, 2 scan length) from i_cfg_wdata.
// Reset (synchronous, active low): scan closed, no ego speed, registers
//   at 1, 500 and 32, output empty.
module radar_track_frame_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // can_id[10:0], payload[74:11], ego_speed_mm_s[91:75], zero pad
    input  logic [rtfd_pkg::TDATA_IN_W-1:0]     i_s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tgt_id[6:0], tgt_status[9:7], pos_x_mm[28:10], pos_y_mm[47:29],
    // vel_x_mm_s[66:48], vel_y_mm_s[85:67], width_half_m[89:86],
    // roll_flag[90], zero pad
    output logic [rtfd_pkg::TDATA_OUT_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [rtfd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rtfd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    rtfd_pkg::t_dp_ctrl dp_ctrl;

    rtfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tuser   (i_s_axis_tuser),
        .i_can_id    (i_s_axis_tdata[10:0]),
        .o_s_tready  (o_s_axis_tready),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tlast   (o_m_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ctrl      (dp_ctrl)
    );

    rtfd_datapath u_datapath (
        .i_clk   (i_clk),
        .i_ctrl  (dp_ctrl),
        .i_tdata (i_s_axis_tdata),
        .o_tdata (o_m_axis_tdata)
    );

endmodule

// ===== test/tb_radar_track_frame_decoder_unit.sv =====
// Testbench for the radar track frame decoder: directed and random streams checked by prediction
`timescale 1ns / 1ps

module tb_radar_track_frame_decoder_unit;

    localparam int ENTRIES   = rtfd_pkg::SINE_TABLE_ENTRIES;
    localparam int VLIM      = 200000;
    localparam int DRAIN_CYC = 40;
    localparam int WDOG_LIM  = 20000;

    typedef struct {
        logic [6:0]         tid;
        logic [2:0]         status;
        logic signed [18:0] px;
        logic signed [18:0] py;
        logic signed [18:0] vx;
        logic signed [18:0] vy;
        logic [3:0]         width;
        logic               roll;
        logic               last;
    } t_track;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    logic [rtfd_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata;
    logic [1:0]                       i_s_axis_tuser;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    logic [rtfd_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata;
    logic                             o_m_axis_tlast;
    logic                             i_cfg_we;
    logic [rtfd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [rtfd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;

    radar_track_frame_decoder_unit uut (.*);

    // predictor state
    int     sin_q15 [ENTRIES];
    bit     ego_en;
    int     fresh_lim;
    int     scan_len;
    bit     scan_on;
    int     scan_cnt;
    int     ego_spd;
    bit     ego_seen;
    int     ego_age;

    t_track tracks_due [$];
    int     errors;
    bit     calm;
    int     wdog;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic void build_sine();
        longint x, term, sum, v;
        for (int k = 0; k < ENTRIES; k++) begin
            x = 64'sd1686629713 * k / (ENTRIES - 1);
            term = x;
            sum = x;
            for (int i = 1; i <= 6; i++) begin
                term = term * x / 64'sd1073741824;
                term = term * x / 64'sd1073741824;
                term = -term / ((2 * i) * (2 * i + 1));
                sum += term;
            end
            v = (sum > 0) ? (sum + 16384) / 32768 : 0;
            if (v > 32767) v = 32767;
            sin_q15[k] = int'(v);
        end
    endfunction

    function automatic longint sin_of_tenths(int t);
        longint num, idx, rem, lo, hi;
        if (t > 900) t = 900;
        num = longint'(t) * (ENTRIES - 1);
        idx = num / 900;
        rem = num % 900;
        if (idx >= ENTRIES - 1) return sin_q15[ENTRIES-1];
        lo = sin_q15[idx];
        hi = sin_q15[idx+1];
        return lo + ((hi - lo) * rem + 450) / 900;
    endfunction

    function automatic longint rnd_q15(longint p);
        longint m;
        m = p < 0 ? -p : p;
        m = (m + 16384) / 32768;
        return p < 0 ? -m : m;
    endfunction

    function automatic longint clip_vel(longint v);
        if (v > VLIM) return VLIM;
        if (v < -VLIM) return -VLIM;
        return v;
    endfunction

    // advance predictor by one accepted item, queue a track if one results
    function automatic void predict_item(rtfd_pkg::t_op op, logic [10:0] id, logic [63:0] pl,
                                         logic [16:0] spd);
        t_track t;
        logic [9:0]  araw;
        logic [13:0] rraw;
        longint rng, ang, mag, c, sy, rr;
        if (op == rtfd_pkg::OP_EGO) begin
            ego_spd = spd; ego_seen = 1; ego_age = 0;
            return;
        end
        if (op == rtfd_pkg::OP_TICK) begin
            if (ego_age < 65535) ego_age++;
            return;
        end
        if (op != rtfd_pkg::OP_FRAME) return;
        if (id == rtfd_pkg::ID_SCAN_OPEN) begin
            scan_on = 1; scan_cnt = 0;
        end else if (!(scan_on && id >= rtfd_pkg::ID_TRK_FIRST
                       && id <= rtfd_pkg::ID_TRK_LAST)) begin
            return;
        end
        araw = {pl[12:8], pl[23:19]};
        rraw = {pl[53:48], pl[63:56]};
        rng  = {pl[18:16], pl[31:24]};
        ang  = $signed(araw);
        mag  = ang < 0 ? -ang : ang;
        c    = sin_of_tenths(900 - int'(mag));
        sy   = sin_of_tenths(int'(mag));
        if (ang > 0) sy = -sy;
        rr = longint'($signed(rraw)) * 10;
        if (ego_en && ego_seen && ego_age < fresh_lim) rr += rnd_q15(longint'(ego_spd) * c);
        scan_cnt = (scan_cnt + 1) & 8'h7f;
        t.last   = scan_cnt >= scan_len;
        if (t.last) scan_on = 0;
        t.tid    = 7'(id - rtfd_pkg::ID_SCAN_OPEN + 11'd1);
        t.status = pl[15:13];
        t.px     = 19'(rnd_q15(rng * 100 * c));
        t.py     = 19'(rnd_q15(rng * 100 * sy));
        t.vx     = 19'(clip_vel(rnd_q15(rr * c)));
        t.vy     = 19'(clip_vel(rnd_q15(rr * sy)));
        t.width  = pl[37:34];
        t.roll   = pl[38];
        tracks_due.insert(tracks_due.size(), t);
    endfunction

    task automatic send_item(rtfd_pkg::t_op op, logic [10:0] id, logic [63:0] pl,
                             logic [16:0] spd);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        repeat (gap) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'b0, spd, pl, id};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_item(op, id, pl, spd);
    endtask

    function automatic logic [63:0] rnd_pl();
        return {$urandom, $urandom};
    endfunction

    task automatic send_track(logic [10:0] id);
        send_item(rtfd_pkg::OP_FRAME, id, rnd_pl(), 17'($urandom));
    endtask

    task automatic send_ego(int spd);
        send_item(rtfd_pkg::OP_EGO, 11'($urandom), rnd_pl(), 17'(spd));
    endtask

    task automatic send_tick();
        send_item(rtfd_pkg::OP_TICK, 11'($urandom), rnd_pl(), 17'($urandom));
    endtask

    // block idle: all tracks out, then a drain wait
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (tracks_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rtfd_pkg::CFG_ADDR_W-1:0] idx, int val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= rtfd_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            rtfd_pkg::CFG_EGO_EN:   ego_en = val[0];
            rtfd_pkg::CFG_FRESH:    fresh_lim = val & 16'hffff;
            rtfd_pkg::CFG_SCAN_LEN: scan_len = val & 7'h7f;
            default: ;
        endcase
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // output side: random stalls, each track compared with the oldest expectation
    initial begin
        t_track e;
        int stall;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 18);
            repeat (stall) begin
                i_m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            if (tracks_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected track, expected none, got id %0d", $time,
                         o_m_axis_tdata[6:0]);
            end else begin
                e = tracks_due.pop_front();
                check_field("tgt_id", e.tid, o_m_axis_tdata[6:0]);
                check_field("tgt_status", e.status, o_m_axis_tdata[9:7]);
                check_field("pos_x_mm", e.px, $signed(o_m_axis_tdata[28:10]));
                check_field("pos_y_mm", e.py, $signed(o_m_axis_tdata[47:29]));
                check_field("vel_x_mm_s", e.vx, $signed(o_m_axis_tdata[66:48]));
                check_field("vel_y_mm_s", e.vy, $signed(o_m_axis_tdata[85:67]));
                check_field("width_half_m", e.width, o_m_axis_tdata[89:86]);
                check_field("roll_flag", e.roll, o_m_axis_tdata[90]);
                check_field("last_of_scan", e.last, o_m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || i_cfg_we || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIM) begin
            $display("tb_radar_track_frame_decoder_unit failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_track(rtfd_pkg::ID_TRK_FIRST);                       // closed scan: dropped
        send_item(rtfd_pkg::OP_FRAME, rtfd_pkg::ID_SCAN_OPEN, 64'h0, 17'd0);
        send_item(rtfd_pkg::OP_FRAME, rtfd_pkg::ID_TRK_FIRST, 64'hffff_ffff_ffff_ffff,
                  17'h1ffff);
        send_item(rtfd_pkg::OP_FRAME, rtfd_pkg::ID_TRK_LAST, 64'h00_20_ff_00_00_07_00_00,
                  17'd0);
        send_item(rtfd_pkg::OP_FRAME, 11'h540, rnd_pl(), 17'd0); // outside track ids
        send_item(rtfd_pkg::OP_FRAME, 11'h7ff, rnd_pl(), 17'd0);
        send_item(rtfd_pkg::OP_FRAME, 11'h000, rnd_pl(), 17'd0);
        send_item(rtfd_pkg::OP_RSVD, rtfd_pkg::ID_SCAN_OPEN, rnd_pl(), 17'd0);
        send_ego(100000);
        // angles +47.6 and +0.2 deg, the second at full range
        send_item(rtfd_pkg::OP_FRAME, 11'h502, 64'h1f_e0_00_00_ff_e1_0e_00, 17'd0);
        send_item(rtfd_pkg::OP_FRAME, 11'h503, 64'h20_00_00_00_ff_17_00_00, 17'd0);
        send_item(rtfd_pkg::OP_FRAME, rtfd_pkg::ID_SCAN_OPEN, rnd_pl(), 17'd0); // restart
        send_tick();
        send_ego(0);
        send_track(11'h510);
    endtask

    task automatic test_scan_limits();
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 1);
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        send_track(rtfd_pkg::ID_TRK_FIRST);
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 0);
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 64);
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        for (int i = 0; i < 63; i++) send_track(11'(rtfd_pkg::ID_TRK_FIRST + i));
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 5);
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        for (int i = 0; i < 3; i++) send_track(11'(rtfd_pkg::ID_TRK_FIRST + i));
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 2);                    // below current count
        send_track(11'h520);
    endtask

    task automatic test_freshness();
        write_reg(rtfd_pkg::CFG_FRESH, 0);                       // never fresh
        send_ego(54321);
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        write_reg(rtfd_pkg::CFG_FRESH, 2);
        send_ego(77777);
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        send_tick();
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        send_tick();
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        write_reg(rtfd_pkg::CFG_EGO_EN, 0);
        send_ego(88888);
        send_track(rtfd_pkg::ID_SCAN_OPEN);
        write_reg(rtfd_pkg::CFG_EGO_EN, 1);
        write_reg(rtfd_pkg::CFG_FRESH, 65535);
        repeat (5) send_tick();
        send_track(rtfd_pkg::ID_SCAN_OPEN);
    endtask

    task automatic test_random(int n_items);
        int sent, k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(rtfd_pkg::t_op'($urandom_range(0, 3)), 11'($urandom), rnd_pl(),
                          17'($urandom_range(0, 100000)));
            end else begin
                send_track(rtfd_pkg::ID_SCAN_OPEN);
                k = $urandom_range(0, scan_len + 2);
                for (int i = 0; i < k; i++) begin
                    case ($urandom_range(0, 7))
                        0: send_ego($urandom_range(0, 100000));
                        1: send_tick();
                        default: send_track(11'($urandom_range(rtfd_pkg::ID_TRK_FIRST,
                                                               rtfd_pkg::ID_TRK_LAST)));
                    endcase
                end
                sent += k;
            end
            sent++;
        end
    endtask

    initial begin
        errors = 0;
        calm   = 0;
        wdog   = 0;
        build_sine();
        ego_en = 1; fresh_lim = 500; scan_len = 32;
        scan_on = 0; scan_cnt = 0; ego_spd = 0; ego_seen = 0; ego_age = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= rtfd_pkg::OP_FRAME;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= rtfd_pkg::CFG_EGO_EN;
        i_cfg_wdata     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_scan_limits();
        test_freshness();

        write_reg(rtfd_pkg::CFG_FRESH, 3);
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 4);
        test_random(200);
        write_reg(rtfd_pkg::CFG_FRESH, 1);
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 64);
        calm = 1;
        test_random(150);
        calm = 0;
        write_reg(rtfd_pkg::CFG_EGO_EN, 0);
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 1);
        test_random(150);
        write_reg(rtfd_pkg::CFG_EGO_EN, 1);
        write_reg(rtfd_pkg::CFG_FRESH, 40);
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 7);
        test_random(200);
        write_reg(rtfd_pkg::CFG_FRESH, 65535);
        write_reg(rtfd_pkg::CFG_SCAN_LEN, 32);
        test_random(250);

        wait_idle();
        if (errors == 0)
            $display("tb_radar_track_frame_decoder_unit passed");
        else
            $display("tb_radar_track_frame_decoder_unit failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rtfd_pkg.sv
hdl/rtfd_ctrl.sv
hdl/rtfd_datapath.sv
hdl/radar_track_frame_decoder_unit.sv
test/tb_radar_track_frame_decoder_unit.sv
